[rtl/core/svew_pkg.sv]
`timescale 1ns / 1ps

package svew_pkg;

  // APB address width: four 32-bit registers at byte offsets 0, 4, 8, 12
  localparam int unsigned ADDR_W = 4;

  // Item kinds carried on the mode field
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_GAZE   = 2'd1,
    MODE_WIGGLE = 2'd2,
    MODE_TARGET = 2'd3
  } mode_t;

  // Register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_CENTER = 2'd0,
    REG_MIN    = 2'd1,
    REG_MAX    = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_t;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    logic [7:0] center_angle;
    logic [7:0] min_angle;
    logic [7:0] max_angle;
    logic [7:0] easing_gain;
  } cfg_t;

  localparam logic [7:0]  CENTER_RESET = 8'd90;
  localparam logic [7:0]  MIN_RESET    = 8'd0;
  localparam logic [7:0]  MAX_RESET    = 8'd180;
  localparam logic [7:0]  GAIN_RESET   = 8'd26;
  localparam logic [15:0] ANGLE_RESET  = 16'd23040;  // 90 degrees, Q8.8

  localparam logic [31:0]        UPDATE_PERIOD_MS = 32'd20;
  localparam logic signed [16:0] EASE_DEADBAND    = 17'sd77;
  localparam logic signed [6:0]  GAZE_SPAN        = 7'sd35;
  localparam logic [2:0]         WIGGLE_STEPS     = 3'd5;

  // Wiggle offsets from centre, whole degrees
  function automatic logic signed [5:0] step_offset(input logic [2:0] idx);
    logic signed [5:0] off;
    case (idx)
      3'd0:    off = -6'sd18;
      3'd1:    off = 6'sd18;
      3'd2:    off = -6'sd12;
      3'd3:    off = 6'sd12;
      default: off = 6'sd0;
    endcase
    return off;
  endfunction

  // Dwell after each wiggle step, ms
  function automatic logic [7:0] step_dwell(input logic [2:0] idx);
    logic [7:0] dw;
    case (idx)
      3'd0, 3'd1: dw = 8'd140;
      3'd2, 3'd3: dw = 8'd120;
      default:    dw = 8'd100;
    endcase
    return dw;
  endfunction

  // Clamp a signed Q8.8 goal to [lo, hi] degrees; when lo > hi, goals below lo give lo and all others give hi
  function automatic logic [15:0] clamp_goal(input logic signed [17:0] x,
                                             input logic [7:0] lo_deg,
                                             input logic [7:0] hi_deg);
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic [15:0] res;
    lo = $signed({2'b00, lo_deg, 8'h00});
    hi = $signed({2'b00, hi_deg, 8'h00});
    if (x < lo) begin
      res = lo[15:0];
    end else if (x > hi) begin
      res = hi[15:0];
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/servo_easing_with_wiggle_sequence.sv]
`timescale 1ns / 1ps
// Servo easing with wiggle sequencer.
// Input register, then result register; a stalled result beat holds the input.
// Throughput: one item per cycle unless a result beat stalls; the whole update sits
// between the two registers.
// Reset (rst, synchronous): config to 90/0/180/26, angles to 90 degrees, timers clear.

module servo_easing_with_wiggle_sequence import svew_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // items
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         mode,
  input  logic signed [15:0] look_x,
  input  logic signed [16:0] target_angle,
  // results
  output logic               result_valid,
  input  logic               result_ready,
  output logic               write_valid,
  output logic [7:0]         servo_angle,
  output logic [15:0]        current_angle,
  output logic               wiggling
);

  cfg_t cfg;

  svew_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  logic               s1_valid;
  mode_t              s1_mode;
  logic signed [15:0] s1_look_x;
  logic signed [16:0] s1_target;
  logic               s1_adv;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_mode   <= mode_t'(mode);
      s1_look_x <= look_x;
      s1_target <= target_angle;
    end
  end

  // Block state
  logic [31:0] time_now, last_update_time, next_step_time;
  logic        wiggle_active;
  logic [2:0]  wiggle_index;
  logic [15:0] present_angle, goal_angle;

  logic [31:0] time_now_next, last_update_time_next, next_step_time_next;
  logic        wiggle_active_next;
  logic [2:0]  wiggle_index_next;
  logic [15:0] present_angle_next, goal_angle_next;

  logic [31:0]        tick_time, elapsed;
  logic signed [22:0] gaze_prod;
  logic signed [17:0] gaze_pos;
  logic signed [5:0]  wig_off;
  logic signed [9:0]  wig_deg;
  logic signed [17:0] wig_pos;
  logic               update_due;

  // Candidate goals
  assign tick_time = time_now + 32'd1;
  assign elapsed   = tick_time - last_update_time;
  assign gaze_prod = s1_look_x * GAZE_SPAN;
  assign gaze_pos  = $signed({2'b00, cfg.center_angle, 8'h00})
                   + $signed({gaze_prod[22], gaze_prod[22:6]});
  assign wig_off   = step_offset(wiggle_index);
  assign wig_deg   = $signed({2'b00, cfg.center_angle})
                   + $signed({{4{wig_off[5]}}, wig_off});
  assign wig_pos   = $signed({wig_deg, 8'h00});

  // Item decode, tick timing and wiggle sequencer
  always_comb begin
    time_now_next         = time_now;
    last_update_time_next = last_update_time;
    next_step_time_next   = next_step_time;
    wiggle_active_next    = wiggle_active;
    wiggle_index_next     = wiggle_index;
    goal_angle_next       = goal_angle;
    update_due            = 1'b0;
    case (s1_mode)
      MODE_GAZE: begin
        if (!wiggle_active) begin
          goal_angle_next = clamp_goal(gaze_pos, cfg.min_angle, cfg.max_angle);
        end
      end
      MODE_WIGGLE: begin
        wiggle_active_next  = 1'b1;
        wiggle_index_next   = '0;
        next_step_time_next = time_now;
      end
      MODE_TARGET: begin
        goal_angle_next = clamp_goal({s1_target[16], s1_target},
                                     cfg.min_angle, cfg.max_angle);
      end
      MODE_TICK: begin
        time_now_next = tick_time;
        if (elapsed >= UPDATE_PERIOD_MS) begin
          update_due            = 1'b1;
          last_update_time_next = tick_time;
          if (wiggle_active && (tick_time >= next_step_time)) begin
            if (wiggle_index < WIGGLE_STEPS) begin
              goal_angle_next     = clamp_goal(wig_pos, cfg.min_angle, cfg.max_angle);
              next_step_time_next = tick_time + {24'd0, step_dwell(wiggle_index)};
              wiggle_index_next   = wiggle_index + 3'd1;
            end else begin
              wiggle_active_next = 1'b0;
              wiggle_index_next  = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Easing step toward the (possibly just updated) goal
  logic        ease_move;
  logic [15:0] ease_angle;
  logic        wrote;
  logic [15:0] rounded;

  svew_ease u_ease (
    .goal          (goal_angle_next),
    .present       (present_angle),
    .gain          (cfg.easing_gain),
    .move          (ease_move),
    .present_moved (ease_angle)
  );

  assign wrote              = update_due && ease_move;
  assign present_angle_next = wrote ? ease_angle : present_angle;
  assign rounded            = present_angle_next + 16'd128;

  // State commit
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now         <= '0;
      last_update_time <= '0;
      next_step_time   <= '0;
      wiggle_active    <= 1'b0;
      wiggle_index     <= '0;
      present_angle    <= ANGLE_RESET;
      goal_angle       <= ANGLE_RESET;
    end else if (s1_adv) begin
      time_now         <= time_now_next;
      last_update_time <= last_update_time_next;
      next_step_time   <= next_step_time_next;
      wiggle_active    <= wiggle_active_next;
      wiggle_index     <= wiggle_index_next;
      present_angle    <= present_angle_next;
      goal_angle       <= goal_angle_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      write_valid   <= wrote;
      servo_angle   <= wrote ? rounded[15:8] : 8'd0;
      current_angle <= present_angle_next;
      wiggling      <= wiggle_active_next;
    end
  end

  // Checks
  a_silent_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !write_valid |-> servo_angle == 8'd0)
    else $error("silent result beat carries a servo angle");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !wiggle_active |-> wiggle_index == 3'd0)
    else $error("wiggle index left non-zero while idle");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    wiggle_index <= WIGGLE_STEPS)
    else $error("wiggle index past last step");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && result_valid && !result_ready |-> !item_ready)
    else $error("input taken while pipeline is stalled");

endmodule

[rtl/core/svew_regs.sv]
`timescale 1ns / 1ps

module svew_regs import svew_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_angle <= CENTER_RESET;
      cfg.min_angle    <= MIN_RESET;
      cfg.max_angle    <= MAX_RESET;
      cfg.easing_gain  <= GAIN_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_CENTER: cfg.center_angle <= pwdata[7:0];
        REG_MIN:    cfg.min_angle    <= pwdata[7:0];
        REG_MAX:    cfg.max_angle    <= pwdata[7:0];
        REG_GAIN:   cfg.easing_gain  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_CENTER: prdata[7:0] = cfg.center_angle;
      REG_MIN:    prdata[7:0] = cfg.min_angle;
      REG_MAX:    prdata[7:0] = cfg.max_angle;
      REG_GAIN:   prdata[7:0] = cfg.easing_gain;
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/core/svew_ease.sv]
`timescale 1ns / 1ps

module svew_ease import svew_pkg::*; (
  input  logic [15:0] goal,
  input  logic [15:0] present,
  input  logic [7:0]  gain,
  output logic        move,
  output logic [15:0] present_moved
);

  logic signed [16:0] diff;
  logic signed [25:0] prod;

  // Remaining distance and its gain-scaled share (floored by the shift)
  assign diff = $signed({1'b0, goal}) - $signed({1'b0, present});
  assign prod = diff * $signed({1'b0, gain});

  // Deadband of 77/256 degree either side
  assign move = (diff > EASE_DEADBAND) || (diff < -EASE_DEADBAND);

  // prod >>> 8, low 16 bits, added modulo 2^16
  assign present_moved = present + prod[23:8];

endmodule
